@@ sv/imu_ts_pkg.sv @@
// shared types and constants of the imu time sync interpolator
`default_nettype none
package imu_ts_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam logic [31:0] GAP_RESET = 32'd200000;

    localparam logic [1:0] ST_SYNCED = 2'd0;
    localparam logic [1:0] ST_AFTER  = 2'd1;
    localparam logic [1:0] ST_FEW    = 2'd2;

    localparam logic signed [19:0] W_ONE = 20'sd65536;
    localparam logic signed [19:0] W_MAX = 20'sd131071;
    localparam logic signed [19:0] W_MIN = -20'sd131072;

    typedef struct packed {
        logic              kind;
        logic [31:0]       timestamp;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       out_time;
        logic signed [15:0] out_accel_x;
        logic signed [15:0] out_accel_y;
        logic signed [15:0] out_accel_z;
        logic signed [15:0] out_gyro_x;
        logic signed [15:0] out_gyro_y;
        logic signed [15:0] out_gyro_z;
        logic signed [15:0] out_quat_w;
        logic signed [15:0] out_quat_x;
        logic signed [15:0] out_quat_y;
        logic signed [15:0] out_quat_z;
    } t_out;

    // one queued sample: channel 0..2 accel, 3..5 gyro, 6..9 quaternion w,x,y,z
    typedef struct packed {
        logic [31:0]      ts;
        logic [9:0][15:0] ch;
    } t_entry;

    function automatic logic [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'h7fff;
        end else if (v < -20'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

endpackage
`default_nettype wire

@@ sv/imu_time_sync_interpolator.sv @@
// imu time sync interpolator: sample queue in memory, stale pruning, interpolation
`default_nettype none
// push: accepted while idle, busy stays low. sync: pruning passes, then weight
// division, channel multiply-add, norm, root, quaternion division (serial divider,
// one channel multiply at a time, bit-pair root); equal times skip weight division,
// zero quaternions skip root and division; status 1/2 results end after the passes.
// o_done pulses for one cycle with the result; the receiver cannot stall.
// synchronous active-low reset clears queue pointers, control and max_gap (200000)
module imu_time_sync_interpolator #(
    parameter int QUEUE_DEPTH = imu_ts_pkg::DEPTH_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    output logic                o_busy,
    input  imu_ts_pkg::t_in     i_item,
    output logic                o_done,
    output imu_ts_pkg::t_out    o_result,
    input  wire                 i_cfg_we,
    input  wire [31:0]          i_cfg_wdata
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;  // memory read of the two oldest slots
    localparam logic [3:0] S_EVAL = 4'd2;  // pruning decision
    localparam logic [3:0] S_WDIV = 4'd3;  // weight division
    localparam logic [3:0] S_CH   = 4'd4;  // channel multiply-add
    localparam logic [3:0] S_CHR  = 4'd5;  // channel round and store
    localparam logic [3:0] S_NORM = 4'd6;  // sum of quaternion squares
    localparam logic [3:0] S_SQRT = 4'd7;  // square root, one bit pair a cycle
    localparam logic [3:0] S_QSET = 4'd8;  // quaternion division setup
    localparam logic [3:0] S_QDIV = 4'd9;  // quaternion division

    logic [3:0]       r_state;
    logic [IW-1:0]    r_head;
    logic [CW-1:0]    r_fill;
    logic [31:0]      r_gap;
    logic [31:0]      r_t;
    logic             r_fin;

    // sample memory with registered read ports
    imu_ts_pkg::t_entry mem [QUEUE_DEPTH];
    imu_ts_pkg::t_entry r_rd0, r_rd1;

    // shared restoring divider
    logic [51:0]      r_num, r_dsh;
    logic [17:0]      r_quo;
    logic [4:0]       r_cnt;
    logic             r_neg, r_sat;

    logic signed [17:0] r_wf, r_wb;
    logic [3:0]       r_ch;
    logic signed [34:0] r_acc;
    logic [9:0][15:0] r_res;
    logic signed [18:0] r_q [4];
    logic [1:0]       r_qi;
    logic [37:0]      r_norm;
    logic [63:0]      r_sv, r_root, r_bit;

    logic             r_done;
    imu_ts_pkg::t_out r_out;

    // queue addressing
    logic [IW-1:0]    w_slot1, w_head_inc, w_wslot;
    logic [CW:0]      w_sum;
    logic             w_full, w_push;
    imu_ts_pkg::t_entry w_went;

    assign w_head_inc = (r_head == IW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_slot1    = w_head_inc;
    assign w_full     = (r_fill == CW'(QUEUE_DEPTH));
    assign w_sum      = (CW+1)'(r_head) + (CW+1)'(r_fill);
    assign w_wslot    = w_full ? r_head :
                        (w_sum >= (CW+1)'(QUEUE_DEPTH)) ? IW'(w_sum - (CW+1)'(QUEUE_DEPTH))
                                                        : IW'(w_sum);
    assign w_push     = (r_state == S_IDLE) && i_start && !i_item.kind;

    always_comb begin
        w_went.ts    = i_item.timestamp;
        w_went.ch[0] = i_item.accel_x;
        w_went.ch[1] = i_item.accel_y;
        w_went.ch[2] = i_item.accel_z;
        w_went.ch[3] = i_item.gyro_x;
        w_went.ch[4] = i_item.gyro_y;
        w_went.ch[5] = i_item.gyro_z;
        w_went.ch[6] = i_item.quat_w;
        w_went.ch[7] = i_item.quat_x;
        w_went.ch[8] = i_item.quat_y;
        w_went.ch[9] = i_item.quat_z;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            mem[w_wslot] <= w_went;
        end
        r_rd0 <= mem[r_head];
        r_rd1 <= mem[w_slot1];
    end

    // pruning tests on the two oldest samples
    logic [31:0] w_f, w_b;
    logic        w_gap_bad;
    assign w_f = r_rd0.ts;
    assign w_b = r_rd1.ts;
    assign w_gap_bad = ((r_t - w_f) > r_gap) || ((w_b - r_t) > r_gap);

    // weight division setup: back weight = round(n * 65536 / d)
    logic signed [32:0] w_n0, w_d0, w_n, w_d;
    logic [32:0]        w_an;
    logic [51:0]        w_wnum, w_dlim;
    assign w_n0   = $signed({1'b0, r_t}) - $signed({1'b0, w_f});
    assign w_d0   = $signed({1'b0, w_b}) - $signed({1'b0, w_f});
    assign w_n    = w_d0[32] ? -w_n0 : w_n0;
    assign w_d    = w_d0[32] ? -w_d0 : w_d0;
    assign w_an   = w_n[32] ? 33'(-w_n) : 33'(w_n);
    assign w_wnum = {3'b0, w_an, 16'b0} + {20'b0, w_d[32:1]};
    assign w_dlim = {1'b0, w_d, 18'b0};

    // divider step
    logic        w_ge;
    assign w_ge = (r_num >= r_dsh);

    // weights from the quotient, saturated
    logic signed [19:0] w_qs, w_wb20, w_wbc, w_wf20, w_wfc;
    assign w_qs   = r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo});
    assign w_wb20 = r_sat ? (r_neg ? imu_ts_pkg::W_MIN : imu_ts_pkg::W_MAX) : w_qs;
    assign w_wbc  = (w_wb20 > imu_ts_pkg::W_MAX) ? imu_ts_pkg::W_MAX :
                    (w_wb20 < imu_ts_pkg::W_MIN) ? imu_ts_pkg::W_MIN : w_wb20;
    assign w_wf20 = imu_ts_pkg::W_ONE - w_wbc;
    assign w_wfc  = (w_wf20 > imu_ts_pkg::W_MAX) ? imu_ts_pkg::W_MAX :
                    (w_wf20 < imu_ts_pkg::W_MIN) ? imu_ts_pkg::W_MIN : w_wf20;

    // channel multiply-add and rounding, ties away from zero
    logic signed [15:0] w_ca, w_cb;
    logic signed [34:0] w_prod, w_accp, w_accn;
    logic signed [18:0] w_rnd;
    assign w_ca   = $signed(r_rd0.ch[r_ch]);
    assign w_cb   = $signed(r_rd1.ch[r_ch]);
    assign w_prod = w_ca * r_wf + w_cb * r_wb;
    assign w_accp = r_acc + 35'sd32768;
    assign w_accn = -r_acc + 35'sd32768;
    assign w_rnd  = r_acc[34] ? -$signed(w_accn[34:16]) : $signed(w_accp[34:16]);

    // norm accumulation
    logic signed [37:0] w_sq;
    logic [37:0]        w_nnorm;
    assign w_sq    = r_q[r_qi] * r_q[r_qi];
    assign w_nnorm = r_norm + 38'(w_sq);

    // square root trial
    logic [63:0] w_trial;
    assign w_trial = r_root + r_bit;

    // quaternion division setup: round(q * 2^27 / r)
    logic signed [18:0] w_qv;
    logic [18:0]        w_aq;
    assign w_qv = r_q[r_qi];
    assign w_aq = w_qv[18] ? 19'(-w_qv) : 19'(w_qv);

    logic signed [19:0] w_qo;
    assign w_qo = r_neg ? -$signed({2'b0, r_quo}) : $signed({2'b0, r_quo});

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_gap   <= imu_ts_pkg::GAP_RESET;
            r_done  <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_gap <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (!i_item.kind) begin
                            // full queue: oldest sample makes room
                            if (w_full) begin
                                r_head <= w_head_inc;
                            end else begin
                                r_fill <= r_fill + 1'b1;
                            end
                        end else begin
                            r_t     <= i_item.timestamp;
                            r_fin   <= 1'b0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (!r_fin && r_fill > CW'(2)) begin
                        if (w_f > r_t) begin
                            r_out   <= {imu_ts_pkg::ST_AFTER, r_t, 160'd0};
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            if (w_b < r_t || w_gap_bad) begin
                                r_head <= w_head_inc;
                                r_fill <= r_fill - 1'b1;
                            end
                            // a gap drop or an in-range pair ends pruning
                            if (!(w_b < r_t)) begin
                                r_fin <= 1'b1;
                            end
                            r_state <= S_RD;
                        end
                    end else if (r_fill < CW'(2)) begin
                        r_out   <= {imu_ts_pkg::ST_FEW, r_t, 160'd0};
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (w_d0 == '0) begin
                        // equal timestamps take the front sample
                        r_wf    <= 18'sd65536;
                        r_wb    <= '0;
                        r_ch    <= '0;
                        r_state <= S_CH;
                    end else begin
                        r_num   <= w_wnum;
                        r_dsh   <= {2'b0, w_d, 17'b0};
                        r_sat   <= (w_wnum >= w_dlim);
                        r_neg   <= w_n[32];
                        r_quo   <= '0;
                        r_cnt   <= 5'd18;
                        r_state <= S_WDIV;
                    end
                end
                S_WDIV: begin
                    if (r_cnt == '0) begin
                        r_wb    <= w_wbc[17:0];
                        r_wf    <= w_wfc[17:0];
                        r_ch    <= '0;
                        r_state <= S_CH;
                    end else begin
                        if (w_ge) begin
                            r_num <= r_num - r_dsh;
                        end
                        r_quo <= {r_quo[16:0], w_ge};
                        r_dsh <= r_dsh >> 1;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_CH: begin
                    r_acc   <= w_prod;
                    r_state <= S_CHR;
                end
                S_CHR: begin
                    if (r_ch < 4'd6) begin
                        r_res[r_ch] <= imu_ts_pkg::sat16(20'(w_rnd));
                    end else begin
                        r_q[2'(r_ch - 4'd6)] <= w_rnd;
                    end
                    r_ch <= r_ch + 1'b1;
                    if (r_ch == 4'd9) begin
                        r_qi    <= '0;
                        r_norm  <= '0;
                        r_state <= S_NORM;
                    end else begin
                        r_state <= S_CH;
                    end
                end
                S_NORM: begin
                    r_norm <= w_nnorm;
                    r_qi   <= r_qi + 1'b1;
                    if (r_qi == 2'd3) begin
                        if (w_nnorm == '0) begin
                            // zero-length quaternion gives zero quaternion outputs
                            r_out   <= {imu_ts_pkg::ST_SYNCED, r_t,
                                        r_res[0], r_res[1], r_res[2],
                                        r_res[3], r_res[4], r_res[5], 64'd0};
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_sv    <= {w_nnorm, 26'b0};
                            r_root  <= '0;
                            r_bit   <= 64'h4000_0000_0000_0000;
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_qi    <= '0;
                        r_state <= S_QSET;
                    end else begin
                        if (r_sv >= w_trial) begin
                            r_sv   <= r_sv - w_trial;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_QSET: begin
                    // quotient stays below 2^16 since root >= |q_i| * 2^13
                    r_num   <= {7'b0, w_aq[17:0], 27'b0} + {21'b0, r_root[31:1]};
                    r_dsh   <= {5'b0, r_root[31:0], 15'b0};
                    r_neg   <= w_qv[18];
                    r_quo   <= '0;
                    r_cnt   <= 5'd16;
                    r_state <= S_QDIV;
                end
                S_QDIV: begin
                    if (r_cnt == '0) begin
                        r_res[4'd6 + 4'(r_qi)] <= imu_ts_pkg::sat16(w_qo);
                        if (r_qi == 2'd3) begin
                            r_out   <= {imu_ts_pkg::ST_SYNCED, r_t,
                                        r_res[0], r_res[1], r_res[2],
                                        r_res[3], r_res[4], r_res[5],
                                        r_res[6], r_res[7], r_res[8],
                                        imu_ts_pkg::sat16(w_qo)};
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_qi    <= r_qi + 1'b1;
                            r_state <= S_QSET;
                        end
                    end else begin
                        if (w_ge) begin
                            r_num <= r_num - r_dsh;
                        end
                        r_quo <= {r_quo[16:0], w_ge};
                        r_dsh <= r_dsh >> 1;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ bench/tb_imu_time_sync_interpolator.sv @@
// self-checking bench for the imu time sync interpolator: predicted sync results vs dut
`default_nettype none
module tb_imu_time_sync_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic       o_busy;
    imu_ts_pkg::t_in  i_item = '0;
    logic       o_done;
    imu_ts_pkg::t_out o_result;
    logic       i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    always #2 i_clk = ~i_clk;

    imu_time_sync_interpolator #(.QUEUE_DEPTH(DEPTH)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // predictor copy of the sample queue
    logic [31:0]        q_time [DEPTH];
    logic signed [15:0] q_chan [DEPTH][10];
    int                 q_head;
    int                 q_fill;
    logic [31:0]        gap_limit;

    imu_ts_pkg::t_out sync_expected[$];
    int   fail_count;
    int   send_idle_pct;
    logic [31:0] time_base;

    function automatic longint round_div(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic logic [15:0] clip16(longint v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic void pop_oldest();
        q_head = (q_head + 1) % DEPTH;
        q_fill--;
    endfunction

    // update the queue model and queue the expected sync result
    function automatic void predict_sync(imu_ts_pkg::t_in it);
        imu_ts_pkg::t_out r;
        int s, s0, s1;
        logic [31:0] f, b, t;
        longint n, d, wb, wf, acc, norm2, rt;
        longint qv[4];
        logic signed [15:0] smp[10];
        smp = '{it.accel_x, it.accel_y, it.accel_z, it.gyro_x, it.gyro_y, it.gyro_z,
                it.quat_w, it.quat_x, it.quat_y, it.quat_z};
        t = it.timestamp;
        if (it.kind == 1'b0) begin
            if (q_fill >= DEPTH) pop_oldest();
            s = (q_head + q_fill) % DEPTH;
            q_time[s] = t;
            for (int i = 0; i < 10; i++) q_chan[s][i] = smp[i];
            q_fill++;
            return;
        end
        r = '0;
        r.out_time = t;
        r.status = imu_ts_pkg::ST_SYNCED;
        while (q_fill > 2) begin
            f = q_time[q_head];
            b = q_time[(q_head + 1) % DEPTH];
            if (f > t) begin
                r.status = imu_ts_pkg::ST_AFTER;
                break;
            end
            if (b < t) begin
                pop_oldest();
                continue;
            end
            if ({32'd0, t} - f > gap_limit || {32'd0, b} - t > gap_limit) pop_oldest();
            break;
        end
        if (r.status == imu_ts_pkg::ST_SYNCED && q_fill < 2) r.status = imu_ts_pkg::ST_FEW;
        if (r.status == imu_ts_pkg::ST_SYNCED) begin
            s0 = q_head;
            s1 = (q_head + 1) % DEPTH;
            n = longint'(t) - longint'(q_time[s0]);
            d = longint'(q_time[s1]) - longint'(q_time[s0]);
            if (d == 0) begin
                wf = 65536;
                wb = 0;
            end else begin
                if (d < 0) begin
                    d = -d;
                    n = -n;
                end
                wb = round_div(n * 65536, d);
                if (wb > 131071) wb = 131071;
                if (wb < -131072) wb = -131072;
                wf = 65536 - wb;
                if (wf > 131071) wf = 131071;
                if (wf < -131072) wf = -131072;
            end
            acc = 0;
            for (int i = 0; i < 6; i++) begin
                acc = round_div(longint'(q_chan[s0][i]) * wf + longint'(q_chan[s1][i]) * wb,
                                65536);
                smp[i] = clip16(acc);
            end
            norm2 = 0;
            for (int i = 0; i < 4; i++) begin
                qv[i] = round_div(longint'(q_chan[s0][6+i]) * wf
                                  + longint'(q_chan[s1][6+i]) * wb, 65536);
                norm2 += qv[i] * qv[i];
                smp[6+i] = '0;
            end
            if (norm2 != 0) begin
                // root of |q|^2 scaled by 2^26 gives |q| in units of 2^-13
                rt = int_sqrt(longint'(norm2) << 26);
                if (rt > 0)
                    for (int i = 0; i < 4; i++) smp[6+i] = clip16(round_div(qv[i] << 27, rt));
            end
            r.out_accel_x = smp[0]; r.out_accel_y = smp[1]; r.out_accel_z = smp[2];
            r.out_gyro_x = smp[3]; r.out_gyro_y = smp[4]; r.out_gyro_z = smp[5];
            r.out_quat_w = smp[6]; r.out_quat_x = smp[7];
            r.out_quat_y = smp[8]; r.out_quat_z = smp[9];
        end
        sync_expected.insert(sync_expected.size(), r);
    endfunction

    // compare each completed sync with the oldest prediction
    always @(posedge i_clk) begin
        imu_ts_pkg::t_out e;
        if (i_rst_n && o_done) begin
            if (sync_expected.size() == 0) begin
                $error("result with nothing expected: %p", o_result);
                fail_count++;
            end else begin
                e = sync_expected[0];
                sync_expected.delete(0);
                if (o_result.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_result.status); fail_count++;
                end
                if (o_result.out_time !== e.out_time) begin
                    $error("out_time exp %0d got %0d", e.out_time, o_result.out_time);
                    fail_count++;
                end
                if (o_result.out_accel_x !== e.out_accel_x) begin
                    $error("out_accel_x exp %0d got %0d", e.out_accel_x, o_result.out_accel_x);
                    fail_count++;
                end
                if (o_result.out_accel_y !== e.out_accel_y) begin
                    $error("out_accel_y exp %0d got %0d", e.out_accel_y, o_result.out_accel_y);
                    fail_count++;
                end
                if (o_result.out_accel_z !== e.out_accel_z) begin
                    $error("out_accel_z exp %0d got %0d", e.out_accel_z, o_result.out_accel_z);
                    fail_count++;
                end
                if (o_result.out_gyro_x !== e.out_gyro_x) begin
                    $error("out_gyro_x exp %0d got %0d", e.out_gyro_x, o_result.out_gyro_x);
                    fail_count++;
                end
                if (o_result.out_gyro_y !== e.out_gyro_y) begin
                    $error("out_gyro_y exp %0d got %0d", e.out_gyro_y, o_result.out_gyro_y);
                    fail_count++;
                end
                if (o_result.out_gyro_z !== e.out_gyro_z) begin
                    $error("out_gyro_z exp %0d got %0d", e.out_gyro_z, o_result.out_gyro_z);
                    fail_count++;
                end
                if (o_result.out_quat_w !== e.out_quat_w) begin
                    $error("out_quat_w exp %0d got %0d", e.out_quat_w, o_result.out_quat_w);
                    fail_count++;
                end
                if (o_result.out_quat_x !== e.out_quat_x) begin
                    $error("out_quat_x exp %0d got %0d", e.out_quat_x, o_result.out_quat_x);
                    fail_count++;
                end
                if (o_result.out_quat_y !== e.out_quat_y) begin
                    $error("out_quat_y exp %0d got %0d", e.out_quat_y, o_result.out_quat_y);
                    fail_count++;
                end
                if (o_result.out_quat_z !== e.out_quat_z) begin
                    $error("out_quat_z exp %0d got %0d", e.out_quat_z, o_result.out_quat_z);
                    fail_count++;
                end
            end
        end
    end

    // one transfer: optional idle cycles, then hold start until accepted
    task automatic send_item(imu_ts_pkg::t_in it);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_item <= it;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_sync(it);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (sync_expected.size() != 0 || o_busy) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_gap(logic [31:0] v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gap_limit = v;
        @(posedge i_clk);
    endtask

    function automatic imu_ts_pkg::t_in make_item(logic kind, logic [31:0] ts);
        imu_ts_pkg::t_in it;
        it = {1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it.kind = kind;
        it.timestamp = ts;
        return it;
    endfunction

    function automatic imu_ts_pkg::t_in make_sample(logic [31:0] ts, logic signed [15:0] a,
                                                    logic signed [15:0] q);
        imu_ts_pkg::t_in it;
        it = '0;
        it.timestamp = ts;
        it.accel_x = a; it.accel_y = -a; it.accel_z = a;
        it.gyro_x = a; it.gyro_y = a; it.gyro_z = -a;
        it.quat_w = q; it.quat_x = q; it.quat_y = -q; it.quat_z = q;
        return it;
    endfunction

    function automatic imu_ts_pkg::t_in make_sync(logic [31:0] ts);
        imu_ts_pkg::t_in it;
        it = '0;
        it.kind = 1'b1;
        it.timestamp = ts;
        return it;
    endfunction

    // extremes, too few samples, sync before oldest, equal times, zero quaternion,
    // extrapolation with weight saturation
    task automatic test_directed();
        send_item(make_sync(32'd0));
        send_item(make_sample(32'd100, 16'sh7fff, 16'sh7fff));
        send_item(make_sync(32'd100));
        send_item(make_sample(32'd100, -16'sh8000, -16'sh8000));
        send_item(make_sync(32'd100));
        send_item(make_sample(32'd200, 16'sd0, 16'sd0));
        send_item(make_sync(32'd50));
        send_item(make_sync(32'd150));
        send_item(make_sync(32'd180));
        send_item(make_sample(32'd210, 16'sd0, 16'sd0));
        send_item(make_sync(32'd205));
        send_item(make_sample(32'd220, 16'sd1000, 16'sd16384));
        send_item(make_sync(32'hffff_ffff));
        send_item(make_sample(32'hffff_fff0, 16'sd5, -16'sd9));
        send_item(make_sync(32'hffff_ffff));
        send_item(make_sync(32'd0));
        // overflow the queue so the oldest samples fall out
        for (int i = 0; i < 20; i++) send_item(make_item(1'b0, 32'd1000 + 32'(i) * 10));
        send_item(make_sync(32'd1100));
    endtask

    // sample stream with jittered times and syncs landing mostly between samples
    task automatic run_random(int items, int pct);
        imu_ts_pkg::t_in it;
        logic [31:0] ts;
        send_idle_pct = pct;
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(99) < 8) begin
                it = make_item(1'($urandom_range(1)), $urandom);
            end else if ($urandom_range(99) < 25) begin
                ts = time_base - 32'($urandom_range(3000)) + 32'($urandom_range(6000));
                it = make_item(1'b1, ts);
            end else begin
                time_base += 32'($urandom_range(1500));
                it = make_item(1'b0, time_base);
                if ($urandom_range(9) == 0) begin
                    it.quat_w = '0; it.quat_x = '0; it.quat_y = '0; it.quat_z = '0;
                end
            end
            send_item(it);
        end
    endtask

    task automatic test_gap_settings();
        write_gap(32'd0);
        run_random(100, 25);
        write_gap(32'hffff_ffff);
        run_random(100, 0);
        write_gap(32'd700);
        run_random(100, 56);
    endtask

    task automatic test_idle_mix();
        write_gap(imu_ts_pkg::GAP_RESET);
        run_random(200, 25);
        wait_drained();
        run_random(200, 56);
        run_random(150, 0);
    endtask

    initial begin
        fail_count = 0;
        q_head = 0;
        q_fill = 0;
        gap_limit = imu_ts_pkg::GAP_RESET;
        send_idle_pct = 0;
        time_base = 32'd5000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_gap_settings();
        test_idle_mix();
        wait_drained();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
sv/imu_ts_pkg.sv
sv/imu_time_sync_interpolator.sv
bench/tb_imu_time_sync_interpolator.sv
